@@ hw/rtl/pfgs_pkg.sv @@
// Shared types and constants for the proportional-fair grant scheduler.
package pfgs_pkg;

    localparam int UserCount = 16;
    localparam int SlotW = $clog2(UserCount);
    localparam int SizeW = 17;
    localparam int BacklogW = 24;
    localparam int AvgW = 33;
    localparam int IdleW = 8;
    localparam int GrantW = 5;
    localparam logic [GrantW-1:0] GrantsReset = GrantW'(4);
    localparam logic [AvgW-1:0] AvgOne = AvgW'(65536);
    localparam logic [IdleW-1:0] IdleMax = {IdleW{1'b1}};

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_REPORT = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]          command;
        logic [3:0]          user_slot;
        logic [3:0]          quality_index;
        logic [BacklogW-1:0] backlog_bytes;
        logic [SizeW-1:0]    block_size_entry;
    } in_item_t;

    typedef struct packed {
        logic [3:0]          granted_slot;
        logic [SizeW-1:0]    granted_size;
        logic [BacklogW-1:0] backlog_left;
        logic [IdleW-1:0]    idle_ticks;
        logic                last_user;
    } out_item_t;

    // Controller commands to the datapath.
    typedef struct packed {
        logic write_item;   // apply load or report
        logic scan_clear;   // start a grant round
        logic scan_step;    // compare one user
        logic mul_step;     // register the products for the compare
        logic grant_apply;  // grant the round winner
        logic upd_step;     // update one user (average / idle)
        logic upd_mul;      // first stage of the average update
        logic div_step;     // upper half of the divide by 20
        logic idx_clear;    // reset the user index
        logic emit_load;    // load the output register for index
    } dp_cmd_t;

    typedef struct packed {
        logic idx_last;
        logic have_best;
    } dp_status_t;

endpackage

@@ hw/rtl/pfgs_datapath.sv @@
// Datapath of the scheduler: user stores, metric compare and state update.
module pfgs_datapath
    import pfgs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  in_item_t   item,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output out_item_t  result
);

    logic [SizeW-1:0]    size_table_reg [16];
    logic [3:0]          quality_reg [UserCount];
    logic [BacklogW-1:0] backlog_reg [UserCount];
    logic [AvgW-1:0]     avg_reg [UserCount];
    logic [IdleW-1:0]    idle_reg [UserCount];
    logic [SizeW-1:0]    given_reg [UserCount];
    logic [UserCount-1:0] taken_reg;
    logic [SlotW-1:0]    idx_reg;
    logic [SlotW-1:0]    best_reg;
    logic                have_best_reg;
    logic [SizeW-1:0]    best_size_reg;
    logic [AvgW-1:0]     best_avg_reg;
    logic [AvgW+SizeW-1:0] lhs_reg, rhs_reg;
    logic                cand_ok_reg;
    logic [AvgW+5-1:0]   upd_sum_reg;
    logic [15:0]         div_hi_reg;
    out_item_t           result_reg;

    logic [SizeW-1:0] cur_size;
    logic [AvgW-1:0]  cur_avg;
    logic             cur_ok;
    logic [35:0]      div_y;
    logic [36:0]      hi_prod;
    logic [2:0]       hi_rem;
    logic [20:0]      lo_val;
    logic [42:0]      lo_prod;

    assign cur_size = size_table_reg[quality_reg[idx_reg]];
    assign cur_avg  = (avg_reg[idx_reg] == '0) ? AvgOne : avg_reg[idx_reg];
    assign cur_ok   = !taken_reg[idx_reg] && backlog_reg[idx_reg] != '0 &&
                      quality_reg[idx_reg] != '0 && cur_size != '0;

    // Divide by 20: drop two bits, then divide by 5 in two 18-bit halves. Each half
    // uses an exact reciprocal multiplication; the upper remainder feeds the lower half.
    assign div_y   = upd_sum_reg[AvgW+5-1:2];
    assign hi_prod = 37'(div_y[35:18]) * 37'd419431;
    assign hi_rem  = 3'(div_y[35:18] - 18'(div_hi_reg) * 18'd5);
    assign lo_val  = {hi_rem, div_y[17:0]};
    assign lo_prod = 43'(lo_val) * 43'd3355444;

    assign status.idx_last  = (idx_reg == SlotW'(UserCount - 1));
    assign status.have_best = have_best_reg;
    assign result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) size_table_reg[i] <= '0;
            for (int i = 0; i < UserCount; i++) begin
                quality_reg[i] <= '0;
                backlog_reg[i] <= '0;
                avg_reg[i] <= '0;
                idle_reg[i] <= '0;
                given_reg[i] <= '0;
            end
            taken_reg <= '0;
            idx_reg <= '0;
            have_best_reg <= 1'b0;
        end else begin
            if (cmd.write_item) begin
                if (item.command == CMD_LOAD) begin
                    size_table_reg[item.quality_index] <= item.block_size_entry;
                end else if (item.command == CMD_REPORT &&
                             {1'b0, item.user_slot} < 5'(UserCount)) begin
                    quality_reg[SlotW'(item.user_slot)] <= item.quality_index;
                    backlog_reg[SlotW'(item.user_slot)] <= item.backlog_bytes;
                end else if (item.command == CMD_TICK) begin
                    taken_reg <= '0;
                    for (int i = 0; i < UserCount; i++) given_reg[i] <= '0;
                end
            end
            if (cmd.idx_clear) idx_reg <= '0;
            if (cmd.scan_clear) begin
                have_best_reg <= 1'b0;
                idx_reg <= '0;
            end
            if (cmd.mul_step) begin
                lhs_reg <= cur_size * best_avg_reg;
                rhs_reg <= best_size_reg * cur_avg;
                cand_ok_reg <= cur_ok;
            end
            if (cmd.scan_step) begin
                if (cand_ok_reg && (!have_best_reg || lhs_reg > rhs_reg)) begin
                    have_best_reg <= 1'b1;
                    best_reg <= idx_reg;
                    best_size_reg <= cur_size;
                    best_avg_reg <= cur_avg;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.grant_apply) begin
                taken_reg[best_reg] <= 1'b1;
                given_reg[best_reg] <= best_size_reg;
                backlog_reg[best_reg] <= (backlog_reg[best_reg] > BacklogW'(best_size_reg))
                    ? backlog_reg[best_reg] - BacklogW'(best_size_reg) : '0;
                idle_reg[best_reg] <= '0;
            end
            if (cmd.upd_mul) begin
                upd_sum_reg <= 38'(avg_reg[idx_reg]) * 38'd19 +
                    (taken_reg[idx_reg] && given_reg[idx_reg] != '0 &&
                     idle_reg[idx_reg] == '0 ? {5'd0, given_reg[idx_reg], 16'd0} : '0);
            end
            if (cmd.div_step) begin
                div_hi_reg <= hi_prod[36:21];
            end
            if (cmd.upd_step) begin
                avg_reg[idx_reg] <= AvgW'({div_hi_reg, 18'd0} + 34'(lo_prod[42:24]));
                if (!taken_reg[idx_reg] && idle_reg[idx_reg] != IdleMax)
                    idle_reg[idx_reg] <= idle_reg[idx_reg] + 1'b1;
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.emit_load) begin
                result_reg.granted_slot <= 4'(idx_reg);
                result_reg.granted_size <= given_reg[idx_reg];
                result_reg.backlog_left <= backlog_reg[idx_reg];
                result_reg.idle_ticks <= idle_reg[idx_reg];
                result_reg.last_user <= status.idx_last;
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/pfgs_ctrl.sv @@
// Controller state machine of the scheduler.
module pfgs_ctrl
    import pfgs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [4:0]   cfg_wdata,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [1:0]   s_command,
    output logic         m_valid,
    input  logic         m_ready,
    input  dp_status_t   status,
    output dp_cmd_t      cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b0_0000_0001,
        ST_MUL   = 9'b0_0000_0010,
        ST_CMP   = 9'b0_0000_0100,
        ST_GRANT = 9'b0_0000_1000,
        ST_UMUL  = 9'b0_0001_0000,
        ST_DIV   = 9'b0_0010_0000,
        ST_UPD   = 9'b0_0100_0000,
        ST_EMIT  = 9'b0_1000_0000,
        ST_OUT   = 9'b1_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [GrantW-1:0] gpt_reg;
    logic [GrantW-1:0] round_reg, round_next;
    logic m_valid_reg, m_valid_next;
    logic last_reg, last_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        round_next = round_reg;
        m_valid_next = m_valid_reg;
        last_next = last_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.write_item = 1'b1;
                    if (s_command == CMD_TICK) begin
                        round_next = '0;
                        cmd.scan_clear = 1'b1;
                        state_next = (gpt_reg == '0) ? ST_UMUL : ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.scan_step = 1'b1;
                state_next = status.idx_last ? ST_GRANT : ST_MUL;
            end
            ST_GRANT: begin
                // Decide after the last compare has settled into have_best.
                // A granted user's average is updated in the final pass, which
                // gives the same result since taken users no longer compete.
                if (status.have_best) begin
                    cmd.grant_apply = 1'b1;
                    round_next = round_reg + 1'b1;
                    if (round_next == gpt_reg) begin
                        state_next = ST_UMUL;
                    end else begin
                        cmd.scan_clear = 1'b1;
                        state_next = ST_MUL;
                    end
                end else begin
                    cmd.idx_clear = 1'b1;
                    round_next = gpt_reg;
                    state_next = ST_UMUL;
                end
            end
            ST_UMUL: begin
                cmd.upd_mul = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd_step = 1'b1;
                state_next = status.idx_last ? ST_EMIT : ST_UMUL;
            end
            ST_EMIT: begin
                cmd.emit_load = 1'b1;
                m_valid_next = 1'b1;
                last_next = status.idx_last;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next = last_reg ? ST_IDLE : ST_EMIT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            gpt_reg <= GrantsReset;
            round_reg <= '0;
            m_valid_reg <= 1'b0;
            last_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            round_reg <= round_next;
            m_valid_reg <= m_valid_next;
            last_reg <= last_next;
            if (cfg_we) gpt_reg <= cfg_wdata;
        end
    end

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped while stalled");
    a_valid_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == ST_OUT) else $error("m_valid outside output state");
    a_round_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> round_reg < gpt_reg) else $error("too many rounds");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("accept while busy");

endmodule

@@ hw/rtl/proportional_fair_grant_scheduler_top.sv @@
// Top level of the proportional-fair grant scheduler; reset (aresetn low, synchronous)
// clears all stores and sets 4 grants per tick. Load and report transactions are
// accepted back to back, one per cycle, while no tick is in progress. A tick runs R
// grant rounds (R is the grant limit, or one more than the eligible users if fewer),
// then an average pass over all users and then 16 results, one per user; the next
// transaction can be taken in the cycle after the last result is accepted.
module proportional_fair_grant_scheduler_top
    import pfgs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic [4:0] cfg_wdata,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    dp_cmd_t    cmd;
    dp_status_t status;

    pfgs_ctrl u_ctrl (
        .aclk, .aresetn, .cfg_we, .cfg_wdata, .s_valid, .s_ready,
        .s_command(s_item.command), .m_valid, .m_ready, .status, .cmd
    );

    pfgs_datapath u_dp (
        .aclk, .aresetn, .item(s_item), .cmd, .status, .result(m_item)
    );

endmodule

@@ verif/tb_proportional_fair_grant_scheduler_top.sv @@
// Self-checking testbench for the proportional-fair grant scheduler top level.
`timescale 1ns / 100ps

module tb_proportional_fair_grant_scheduler_top
    import pfgs_pkg::*;
();

    localparam int WatchdogLimit = 200000;
    localparam int DrainCycles = 400;
    localparam int InBits = $bits(in_item_t);

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [4:0] cfg_wdata = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_item = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_item;

    proportional_fair_grant_scheduler_top DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Scheduler mirror state.
    logic [SizeW-1:0]    sched_table [16];
    logic [3:0]          sched_quality [UserCount];
    logic [BacklogW-1:0] sched_backlog [UserCount];
    logic [AvgW-1:0]     sched_avg [UserCount];
    logic [IdleW-1:0]    sched_idle [UserCount];
    logic [GrantW-1:0]   sched_grants;

    out_item_t grant_queue[$];
    int        error_count = 0;
    int        ticks_sent = 0;
    int        results_seen = 0;
    int        stall_pct = 0;
    int        gap_pct = 0;
    bit        hold_off = 1'b0;
    int        idle_cycles = 0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic bit is_eligible(input int u, input logic [UserCount-1:0] taken);
        if (taken[u] || sched_backlog[u] == 0 || sched_quality[u] == 0) return 1'b0;
        return sched_table[sched_quality[u]] != 0;
    endfunction

    // Applies one transaction to the mirror state and queues the tick results.
    task automatic predict_grants(input in_item_t it);
        logic [UserCount-1:0] taken;
        logic [SizeW-1:0]     given [UserCount];
        logic [63:0]          best_size, best_avg, sz, av;
        int                   best;
        out_item_t            r;
        if (it.command == CMD_LOAD) begin
            sched_table[it.quality_index] = it.block_size_entry;
            return;
        end
        if (it.command == CMD_REPORT) begin
            sched_quality[it.user_slot] = it.quality_index;
            sched_backlog[it.user_slot] = it.backlog_bytes;
            return;
        end
        if (it.command != CMD_TICK) return;
        taken = '0;
        for (int u = 0; u < UserCount; u++) given[u] = '0;
        for (int rnd = 0; rnd < sched_grants; rnd++) begin
            best = -1;
            best_size = 0;
            best_avg = 1;
            for (int u = 0; u < UserCount; u++) begin
                if (!is_eligible(u, taken)) continue;
                sz = 64'(sched_table[sched_quality[u]]);
                av = (sched_avg[u] == 0) ? 64'(AvgOne) : 64'(sched_avg[u]);
                if (best < 0 || sz * best_avg > best_size * av) begin
                    best = u;
                    best_size = sz;
                    best_avg = av;
                end
            end
            if (best < 0) break;
            given[best] = SizeW'(best_size);
            sched_backlog[best] = (sched_backlog[best] > best_size)
                ? sched_backlog[best] - BacklogW'(best_size) : '0;
            sched_avg[best] = AvgW'((64'd19 * sched_avg[best] + (best_size << 16)) / 20);
            sched_idle[best] = '0;
            taken[best] = 1'b1;
        end
        for (int u = 0; u < UserCount; u++) begin
            if (taken[u]) continue;
            sched_avg[u] = AvgW'((64'd19 * sched_avg[u]) / 20);
            if (sched_idle[u] != IdleMax) sched_idle[u]++;
        end
        for (int u = 0; u < UserCount; u++) begin
            r.granted_slot = 4'(u);
            r.granted_size = given[u];
            r.backlog_left = sched_backlog[u];
            r.idle_ticks = sched_idle[u];
            r.last_user = (u == UserCount - 1);
            grant_queue.push_back(r);
        end
        ticks_sent++;
    endtask

    // Valid drops only while the sender idles, so a transaction that follows
    // directly keeps it high without a second assignment in the same step.
    task automatic send_item(input in_item_t it);
        while (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_item <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_grants(it);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (grant_queue.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_grants(input logic [4:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sched_grants = value;
    endtask

    function automatic in_item_t make_item(input cmd_t c, input int slot, input int q,
                                           input int bl, input int sz);
        in_item_t it;
        it.command = c;
        it.user_slot = 4'(slot);
        it.quality_index = 4'(q);
        it.backlog_bytes = BacklogW'(bl);
        it.block_size_entry = SizeW'(sz);
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int pick;
        it = in_item_t'(InBits'({$urandom, $urandom}));
        pick = $urandom_range(99, 0);
        if (pick < 25) it.command = CMD_LOAD;
        else if (pick < 70) it.command = CMD_REPORT;
        else if (pick < 96) it.command = CMD_TICK;
        else it.command = CMD_NONE;
        // Keep backlogs small most of the time so that users drain to zero.
        if ($urandom_range(3, 0) != 0) it.backlog_bytes = BacklogW'($urandom_range(300000, 0));
        return it;
    endfunction

    // Result checking on the output channel.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (grant_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected result slot %0d", m_item.granted_slot));
            end else begin
                want = grant_queue.pop_front();
                if (m_item.granted_slot !== want.granted_slot)
                    report_mismatch($sformatf("slot %0d want %0d",
                        m_item.granted_slot, want.granted_slot));
                if (m_item.granted_size !== want.granted_size)
                    report_mismatch($sformatf("slot %0d size %0d want %0d",
                        want.granted_slot, m_item.granted_size, want.granted_size));
                if (m_item.backlog_left !== want.backlog_left)
                    report_mismatch($sformatf("slot %0d backlog %0d want %0d",
                        want.granted_slot, m_item.backlog_left, want.backlog_left));
                if (m_item.idle_ticks !== want.idle_ticks)
                    report_mismatch($sformatf("slot %0d idle %0d want %0d",
                        want.granted_slot, m_item.idle_ticks, want.idle_ticks));
                if (m_item.last_user !== want.last_user)
                    report_mismatch($sformatf("slot %0d last %0b want %0b",
                        want.granted_slot, m_item.last_user, want.last_user));
            end
        end
    end

    // Receiver readiness; m_ready is held low during the long hold-off.
    always @(posedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= !(stall_pct > 0 && $urandom_range(99, 0) < stall_pct);
    end

    initial begin
        wait (hold_off);
        repeat (1500) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("Watchdog expired with %0d results pending", grant_queue.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    in_item_t directed [$];
    logic [4:0] phase_grants [4] = '{5'd31, 5'd0, 5'd1, 5'd16};

    initial begin
        for (int i = 0; i < 16; i++) sched_table[i] = '0;
        for (int u = 0; u < UserCount; u++) begin
            sched_quality[u] = '0;
            sched_backlog[u] = '0;
            sched_avg[u] = '0;
            sched_idle[u] = '0;
        end
        sched_grants = GrantsReset;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: tick from reset, table extremes, quality zero, extremes.
        directed.push_back(make_item(CMD_TICK, 0, 0, 0, 0));
        directed.push_back(make_item(CMD_LOAD, 0, 0, 0, 5000));
        directed.push_back(make_item(CMD_LOAD, 0, 15, 0, 131071));
        directed.push_back(make_item(CMD_LOAD, 0, 7, 0, 1));
        directed.push_back(make_item(CMD_REPORT, 0, 0, 1000, 0));
        directed.push_back(make_item(CMD_REPORT, 15, 15, 16777215, 0));
        directed.push_back(make_item(CMD_REPORT, 3, 7, 1, 0));
        directed.push_back(make_item(CMD_REPORT, 4, 7, 1, 0));
        directed.push_back(make_item(CMD_REPORT, 5, 9, 500, 0));
        directed.push_back(make_item(CMD_NONE, 2, 15, 16777215, 131071));
        directed.push_back(make_item(CMD_TICK, 15, 15, 16777215, 131071));
        directed.push_back(make_item(CMD_TICK, 0, 0, 0, 0));
        directed.push_back(make_item(CMD_LOAD, 0, 15, 0, 0));
        directed.push_back(make_item(CMD_TICK, 0, 0, 0, 0));
        foreach (directed[i]) send_item(directed[i]);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            write_grants(phase_grants[ph]);
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 60; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 60; hold_off = 1'b1; end
                default: begin gap_pct = 23; stall_pct = 23; end
            endcase
            for (int n = 0; n < 22; n++) send_item(random_item());
            gap_pct = 0;
            stall_pct = 0;
            wait_idle();
        end
        write_grants(GrantsReset);
        for (int n = 0; n < 6; n++) send_item(random_item());
        wait_idle();

        $display("Covered %0d ticks and %0d per-user results over five grant limits,",
                 ticks_sent, results_seen);
        $display("with sender gaps, receiver stalls and one long output hold-off.");
        if (error_count == 0 && grant_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
